FILE: hw/rtl/atcw_pkg.sv
package atcw_pkg;

  // Field widths of the request and response beats.
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 14;
  localparam int CELL_W   = 16;

  // Default geometry.
  localparam int COLUMNS_DEF       = 80;
  localparam int VISIBLE_LINES_DEF = 25;
  localparam int TAB_STOP_DEF      = 8;
  localparam int BUFFER_LINES_DEF  = 200;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Byte codes.
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL_END  = 8'h80;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI     = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_QMARK    = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_FINAL_M  = 8'h6D;

  // Attribute values and SGR operands.
  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CHAR_W-1:0] ATTR_BOLD  = 8'h08;
  localparam logic [CHAR_W-1:0] ATTR_BLINK = 8'h80;
  localparam logic [CHAR_W-1:0] SGR_RESET  = 8'd0;
  localparam logic [CHAR_W-1:0] SGR_BOLD   = 8'd1;
  localparam logic [CHAR_W-1:0] SGR_BLINK  = 8'd5;
  localparam logic [CHAR_W-1:0] SGR_FG_LO  = 8'd30;
  localparam logic [CHAR_W-1:0] SGR_FG_HI  = 8'd37;
  localparam logic [CHAR_W-1:0] SGR_BG_LO  = 8'd40;
  localparam logic [CHAR_W-1:0] SGR_BG_HI  = 8'd47;
  localparam logic [CHAR_W-1:0] ACC_MAX    = 8'd255;

  localparam logic [CELL_W-1:0] BLANK_CELL = {ATTR_RESET, CH_SPACE};

  // Cursor movements requested from the position tracker.
  typedef enum logic [2:0] {
    MV_NONE,
    MV_STEP,
    MV_NEWLINE,
    MV_RETURN,
    MV_HOME
  } move_t;

  typedef struct packed {
    logic overflow;
    logic tab_hit;
  } cur_status_t;

  // ANSI color order is BGR, VGA is RGB: swap bits 0 and 2.
  function automatic logic [2:0] swap_red_blue(logic [2:0] v);
    return {v[0], v[1], v[2]};
  endfunction

  function automatic logic [CHAR_W-1:0] apply_operand(logic [CHAR_W-1:0] attr,
                                                      logic [CHAR_W-1:0] n);
    logic [CHAR_W-1:0] fg_ofs;
    logic [CHAR_W-1:0] bg_ofs;
    logic [CHAR_W-1:0] res;
    fg_ofs = n - SGR_FG_LO;
    bg_ofs = n - SGR_BG_LO;
    res    = attr;
    priority if (n == SGR_RESET) begin
      res = ATTR_RESET;
    end else if (n == SGR_BOLD) begin
      res = attr | ATTR_BOLD;
    end else if (n == SGR_BLINK) begin
      res = attr | ATTR_BLINK;
    end else if (n >= SGR_FG_LO && n <= SGR_FG_HI) begin
      res = {attr[7:3], swap_red_blue(fg_ofs[2:0])};
    end else if (n >= SGR_BG_LO && n <= SGR_BG_HI) begin
      res = {attr[7], swap_red_blue(bg_ofs[2:0]), attr[3:0]};
    end else begin
      // Any other operand leaves the attribute alone.
      res = attr;
    end
    return res;
  endfunction

  // acc * 10 + digit, saturating at the top of the byte.
  function automatic logic [CHAR_W-1:0] acc_digit(logic [CHAR_W-1:0] acc,
                                                  logic [CHAR_W-1:0] b);
    logic [11:0] wide;
    logic [CHAR_W-1:0] d;
    d    = b - CH_ZERO;
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {4'b0, d};
    return (wide > {4'b0, ACC_MAX}) ? ACC_MAX : wide[CHAR_W-1:0];
  endfunction

  // Cursor movement caused by a byte outside an escape sequence.
  function automatic move_t plain_move(logic [CHAR_W-1:0] b);
    move_t m;
    priority if (b == CH_LF) begin
      m = MV_NEWLINE;
    end else if (b == CH_CR) begin
      m = MV_RETURN;
    end else if (b == CH_ESC) begin
      m = MV_NONE;
    end else begin
      m = MV_STEP;
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/atcw_if.sv
interface atcw_req_if;
  logic                              valid;
  logic                              ready;
  logic [atcw_pkg::ACTION_W-1:0]     action;
  logic [atcw_pkg::CHAR_W-1:0]       data_byte;
  logic [atcw_pkg::POS_W-1:0]        cell_index;

  modport source (output valid, action, data_byte, cell_index, input ready);
  modport sink (input valid, action, data_byte, cell_index, output ready);
endinterface

interface atcw_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [atcw_pkg::POS_W-1:0]        cursor_pos;
  logic [atcw_pkg::POS_W-1:0]        view_start;
  logic [atcw_pkg::CHAR_W-1:0]       cell_char;
  logic [atcw_pkg::CHAR_W-1:0]       cell_attr;

  modport source (output valid, cursor_pos, view_start, cell_char, cell_attr, input ready);
  modport sink (input valid, cursor_pos, view_start, cell_char, cell_attr, output ready);
endinterface

FILE: hw/rtl/atcw_cursor.sv
// Tracks the cursor as column, row and linear index, together with the tab
// phase of the row start and of the column, so that no division is needed.
module atcw_cursor #(
  parameter int COLUMNS       = atcw_pkg::COLUMNS_DEF,
  parameter int VISIBLE_LINES = atcw_pkg::VISIBLE_LINES_DEF,
  parameter int TAB_STOP      = atcw_pkg::TAB_STOP_DEF,
  parameter int BUFFER_LINES  = atcw_pkg::BUFFER_LINES_DEF,
  localparam int CELL_COUNT   = COLUMNS * BUFFER_LINES,
  localparam int AW           = $clog2(CELL_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  atcw_pkg::move_t       cmd,
  output atcw_pkg::cur_status_t status,
  output logic [AW-1:0]         cursor,
  output logic [AW-1:0]         cursor_next,
  output logic [AW-1:0]         view_next
);

  localparam int CLW = $clog2(COLUMNS);
  localparam int RW  = $clog2(BUFFER_LINES);
  localparam int TW  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int VW  = $clog2(BUFFER_LINES + VISIBLE_LINES + 1);

  localparam logic [CLW-1:0] LAST_COL   = CLW'(COLUMNS - 1);
  localparam logic [RW-1:0]  LAST_ROW   = RW'(BUFFER_LINES - 1);
  localparam logic [AW-1:0]  LINE_STEP  = AW'(COLUMNS);
  localparam logic [AW-1:0]  LAST_START = AW'((BUFFER_LINES - 1) * COLUMNS);
  localparam logic [AW-1:0]  VIEW_BACK  = AW'((VISIBLE_LINES - 1) * COLUMNS);
  localparam logic [TW-1:0]  LINE_PHASE = TW'(COLUMNS % TAB_STOP);
  localparam logic [TW-1:0]  LAST_PHASE = TW'(((BUFFER_LINES - 1) * COLUMNS) % TAB_STOP);
  localparam logic [TW-1:0]  LAST_TAB   = TW'(TAB_STOP - 1);
  localparam logic [TW:0]    TAB_WRAP   = (TW + 1)'(TAB_STOP);
  localparam logic [VW-1:0]  SHOWN      = VW'(VISIBLE_LINES);

  logic [CLW-1:0] col, col_next;
  logic [RW-1:0]  row, row_next;
  logic [AW-1:0]  rstart, rstart_next;
  logic [TW-1:0]  cphase, cphase_next;
  logic [TW-1:0]  rphase, rphase_next;
  logic [RW-1:0]  vrow, vrow_next;
  logic [AW-1:0]  first_shown;

  logic           line_adv;
  logic           last_row;
  logic [TW:0]    rphase_sum;
  logic [TW:0]    tab_sum;
  logic [TW-1:0]  cphase_inc;

  always_comb begin
    col_next    = col;
    row_next    = row;
    rstart_next = rstart;
    cphase_next = cphase;
    rphase_next = rphase;
    line_adv    = 1'b0;
    rphase_sum  = {1'b0, rphase} + {1'b0, LINE_PHASE};
    cphase_inc  = (cphase == LAST_TAB) ? '0 : cphase + 1'b1;
    last_row    = (row == LAST_ROW);

    unique case (cmd)
      atcw_pkg::MV_STEP: begin
        if (col == LAST_COL) begin
          line_adv = 1'b1;
        end else begin
          col_next    = col + 1'b1;
          cphase_next = cphase_inc;
        end
      end
      atcw_pkg::MV_NEWLINE: begin
        line_adv = 1'b1;
      end
      atcw_pkg::MV_RETURN: begin
        col_next    = '0;
        cphase_next = '0;
      end
      atcw_pkg::MV_HOME: begin
        col_next    = '0;
        row_next    = '0;
        rstart_next = '0;
        cphase_next = '0;
        rphase_next = '0;
      end
      default: begin
      end
    endcase

    // Running past the last line lands at the start of the last line; the
    // buffer contents are moved up by the caller.
    if (line_adv) begin
      col_next    = '0;
      cphase_next = '0;
      if (last_row) begin
        row_next    = LAST_ROW;
        rstart_next = LAST_START;
        rphase_next = LAST_PHASE;
      end else begin
        row_next    = row + 1'b1;
        rstart_next = rstart + LINE_STEP;
        rphase_next = (rphase_sum >= TAB_WRAP) ? TW'(rphase_sum - TAB_WRAP)
                                               : TW'(rphase_sum);
      end
    end

    cursor_next = rstart_next + AW'(col_next);

    tab_sum         = {1'b0, rphase_next} + {1'b0, cphase_next};
    status.overflow = line_adv && last_row;
    status.tab_hit  = (tab_sum == '0) || (tab_sum == TAB_WRAP);

    // The view scrolls so that the cursor line becomes its bottom line.
    vrow_next = vrow;
    view_next = first_shown;
    if (cmd == atcw_pkg::MV_HOME) begin
      vrow_next = '0;
      view_next = '0;
    end else if (VW'(row_next) >= VW'(vrow) + SHOWN) begin
      vrow_next = RW'(VW'(row_next) + 1'b1 - SHOWN);
      view_next = rstart_next - VIEW_BACK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      rstart      <= '0;
      cphase      <= '0;
      rphase      <= '0;
      vrow        <= '0;
      first_shown <= '0;
      cursor      <= '0;
    end else begin
      col         <= col_next;
      row         <= row_next;
      rstart      <= rstart_next;
      cphase      <= cphase_next;
      rphase      <= rphase_next;
      vrow        <= vrow_next;
      first_shown <= view_next;
      cursor      <= cursor_next;
    end
  end

endmodule

FILE: hw/rtl/ansi_text_console_writer_top.sv
// Text console writer: each request beat carries an action. A put action feeds
// one byte into a character-cell buffer of COLUMNS x BUFFER_LINES cells held in
// a single-port-write, single-port-read memory (16 bits per cell: character in
// the low byte, VGA attribute in the high byte). Printable bytes are written at
// the cursor, LF/CR/TAB move it, and ESC [ n;n... m sequences set the attribute
// (colors 30-37 and 40-47 are mapped from ANSI to VGA order). A read action
// returns one cell; a clear action blanks the buffer and resets all state.
// Every request produces exactly one response beat with the cursor position and
// the first displayed cell after the action. A tab moves the cursor cell by cell
// to the next tab stop, at most TAB_STOP cells; an ESC followed by anything but
// '[' writes '?' at the cursor and the byte is then handled as plain. When the
// cursor runs past the last line, the buffer moves up one line with one memory
// read and one write per cell. After reset the block first blanks the memory and
// accepts no request during that pass. A response that has not been taken holds
// off the next request until it is taken.
module ansi_text_console_writer_top #(
  parameter int COLUMNS       = atcw_pkg::COLUMNS_DEF,
  parameter int VISIBLE_LINES = atcw_pkg::VISIBLE_LINES_DEF,
  parameter int TAB_STOP      = atcw_pkg::TAB_STOP_DEF,
  parameter int BUFFER_LINES  = atcw_pkg::BUFFER_LINES_DEF
) (
  input logic         clk,
  input logic         rst,
  atcw_req_if.sink    request,
  atcw_rsp_if.source  response
);

  localparam int CELL_COUNT = COLUMNS * BUFFER_LINES;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int SCW        = $clog2(CELL_COUNT + 1);
  localparam int CW         = atcw_pkg::CHAR_W;

  localparam logic [SCW-1:0] SCAN_END   = SCW'(CELL_COUNT);
  localparam logic [SCW-1:0] SCAN_LAST  = SCW'(CELL_COUNT - 1);
  localparam logic [SCW-1:0] COPY_LIMIT = SCW'(CELL_COUNT - COLUMNS);
  localparam logic [SCW-1:0] SCAN_LINE  = SCW'(COLUMNS);

  // Sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PLAIN  = 6'b000010,
    S_TAB    = 6'b000100,
    S_SCROLL = 6'b001000,
    S_READ   = 6'b010000,
    S_CLEAR  = 6'b100000
  } state_t;

  // Escape sequence parser states.
  typedef enum logic [2:0] {
    P_IDLE = 3'b001,
    P_ESC  = 3'b010,
    P_CSI  = 3'b100
  } phase_t;

  state_t  state, state_next;
  phase_t  phase, phase_next;
  logic [CW-1:0] acc, acc_next;
  logic [CW-1:0] pend_attr, pend_next;
  logic [CW-1:0] cur_attr, cur_next;
  logic          held, held_next;
  logic [CW-1:0] held_byte, held_byte_next;
  logic [SCW-1:0] scan, scan_next;
  logic          clear_reply, clear_reply_next;
  logic          in_range, in_range_next;

  logic          accept;
  logic          finish;
  logic [CW-1:0] byte_in;
  logic [CW-1:0] plain_byte;
  logic          plain;
  logic          plain_print;
  logic          plain_moves_only;
  logic [CW-1:0] operand_attr;

  atcw_pkg::move_t       mv;
  atcw_pkg::cur_status_t status;
  logic [AW-1:0]         cursor;
  logic [AW-1:0]         cursor_next;
  logic [AW-1:0]         view_next;

  // Cell memory.
  logic [atcw_pkg::CELL_W-1:0] cells [CELL_COUNT];
  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [atcw_pkg::CELL_W-1:0] mem_wd;
  logic [AW-1:0]               mem_ra;
  logic [atcw_pkg::CELL_W-1:0] rd_q;

  // Response register.
  logic                        rsp_valid;
  logic [atcw_pkg::POS_W-1:0]  rsp_cursor;
  logic [atcw_pkg::POS_W-1:0]  rsp_view;
  logic [CW-1:0]               rsp_char;
  logic [CW-1:0]               rsp_attr;

  assign request.ready = (state == S_IDLE) && (!rsp_valid || response.ready);
  assign accept        = request.valid && request.ready;
  assign byte_in       = request.data_byte;

  assign response.valid      = rsp_valid;
  assign response.cursor_pos = rsp_cursor;
  assign response.view_start = rsp_view;
  assign response.cell_char  = rsp_char;
  assign response.cell_attr  = rsp_attr;

  atcw_cursor #(
    .COLUMNS       (COLUMNS),
    .VISIBLE_LINES (VISIBLE_LINES),
    .TAB_STOP      (TAB_STOP),
    .BUFFER_LINES  (BUFFER_LINES)
  ) u_cursor (
    .clk         (clk),
    .rst         (rst),
    .cmd         (mv),
    .status      (status),
    .cursor      (cursor),
    .cursor_next (cursor_next),
    .view_next   (view_next)
  );

  // Cursor movement for this cycle. Kept apart from the sequencer, which
  // looks at the tracker's status for the same movement.
  always_comb begin
    mv = atcw_pkg::MV_NONE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (request.action == atcw_pkg::ACT_CLEAR) begin
            mv = atcw_pkg::MV_HOME;
          end else if (request.action == atcw_pkg::ACT_PUT) begin
            if (phase == P_ESC) begin
              mv = (byte_in == atcw_pkg::CH_LBRACKET) ? atcw_pkg::MV_NONE
                                                     : atcw_pkg::MV_STEP;
            end else if (phase == P_IDLE) begin
              mv = atcw_pkg::plain_move(byte_in);
            end
          end
        end
      end
      S_PLAIN: mv = atcw_pkg::plain_move(held_byte);
      S_TAB:   mv = atcw_pkg::MV_STEP;
      default: mv = atcw_pkg::MV_NONE;
    endcase
  end

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    acc_next         = acc;
    pend_next        = pend_attr;
    cur_next         = cur_attr;
    held_next        = held;
    held_byte_next   = held_byte;
    scan_next        = scan;
    clear_reply_next = clear_reply;
    in_range_next    = in_range;
    finish           = 1'b0;
    plain            = 1'b0;
    plain_byte       = held_byte;
    mem_we           = 1'b0;
    mem_wa           = cursor;
    mem_wd           = {cur_attr, atcw_pkg::CH_QMARK};
    mem_ra           = AW'(request.cell_index);
    operand_attr     = atcw_pkg::apply_operand(pend_attr, acc);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (request.action)
            atcw_pkg::ACT_PUT: begin
              priority if (phase == P_ESC) begin
                phase_next = P_IDLE;
                if (byte_in == atcw_pkg::CH_LBRACKET) begin
                  phase_next = P_CSI;
                  acc_next   = '0;
                  pend_next  = cur_attr;
                  finish     = 1'b1;
                end else begin
                  // Broken escape: print '?', then treat the byte as plain.
                  mem_we         = 1'b1;
                  held_next      = 1'b1;
                  held_byte_next = byte_in;
                  scan_next      = '0;
                  state_next     = status.overflow ? S_SCROLL : S_PLAIN;
                end
              end else if (phase == P_CSI) begin
                if (byte_in >= atcw_pkg::CH_ZERO && byte_in <= atcw_pkg::CH_NINE) begin
                  acc_next = atcw_pkg::acc_digit(acc, byte_in);
                end else begin
                  pend_next = operand_attr;
                  acc_next  = '0;
                  if (byte_in != atcw_pkg::CH_SEMI) begin
                    if (byte_in == atcw_pkg::CH_FINAL_M) begin
                      cur_next = operand_attr;
                    end
                    phase_next = P_IDLE;
                  end
                end
                finish = 1'b1;
              end else begin
                plain      = 1'b1;
                plain_byte = byte_in;
              end
            end
            atcw_pkg::ACT_READ: begin
              in_range_next = (32'(request.cell_index) < CELL_COUNT);
              state_next    = S_READ;
            end
            atcw_pkg::ACT_CLEAR: begin
              phase_next       = P_IDLE;
              acc_next         = '0;
              pend_next        = atcw_pkg::ATTR_RESET;
              cur_next         = atcw_pkg::ATTR_RESET;
              held_next        = 1'b0;
              scan_next        = '0;
              clear_reply_next = 1'b1;
              state_next       = S_CLEAR;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      S_PLAIN: begin
        plain = 1'b1;
      end

      S_TAB: begin
        if (status.overflow) begin
          scan_next  = '0;
          state_next = S_SCROLL;
        end else if (status.tab_hit) begin
          finish = 1'b1;
        end
      end

      S_SCROLL: begin
        // Read runs one cell ahead of the write: cell s+COLUMNS is read while
        // cell s-1 receives the data read in the previous cycle.
        mem_ra = AW'(scan + SCAN_LINE);
        if (scan != '0) begin
          mem_we = 1'b1;
          mem_wa = AW'(scan - 1'b1);
          mem_wd = (scan <= COPY_LIMIT) ? rd_q : {cur_attr, atcw_pkg::CH_SPACE};
        end
        if (scan == SCAN_END) begin
          if (held) begin
            state_next = S_PLAIN;
          end else begin
            finish = 1'b1;
          end
        end else begin
          scan_next = scan + 1'b1;
        end
      end

      S_READ: begin
        finish = 1'b1;
      end

      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = AW'(scan);
        mem_wd = atcw_pkg::BLANK_CELL;
        if (scan == SCAN_LAST) begin
          clear_reply_next = 1'b0;
          if (clear_reply) begin
            finish = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          scan_next = scan + 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Byte outside an escape sequence, either fresh or held after a broken ESC.
    plain_print      = (plain_byte >= atcw_pkg::CH_SPACE) &&
                       (plain_byte < atcw_pkg::CH_DEL_END);
    plain_moves_only = (plain_byte == atcw_pkg::CH_LF) || (plain_byte == atcw_pkg::CH_CR) ||
                       (plain_byte == atcw_pkg::CH_TAB) || (plain_byte == atcw_pkg::CH_ESC);
    if (plain) begin
      held_next = 1'b0;
      if (!plain_moves_only) begin
        mem_we = 1'b1;
        mem_wd = {cur_attr, plain_print ? plain_byte : atcw_pkg::CH_QMARK};
      end
      priority if (plain_byte == atcw_pkg::CH_ESC) begin
        phase_next = P_ESC;
        finish     = 1'b1;
      end else if (status.overflow) begin
        scan_next  = '0;
        state_next = S_SCROLL;
      end else if (plain_byte == atcw_pkg::CH_TAB && !status.tab_hit) begin
        state_next = S_TAB;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_wa] <= mem_wd;
    end
    rd_q <= cells[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      phase       <= P_IDLE;
      acc         <= '0;
      pend_attr   <= atcw_pkg::ATTR_RESET;
      cur_attr    <= atcw_pkg::ATTR_RESET;
      held        <= 1'b0;
      scan        <= '0;
      clear_reply <= 1'b0;
      in_range    <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      acc         <= acc_next;
      pend_attr   <= pend_next;
      cur_attr    <= cur_next;
      held        <= held_next;
      scan        <= scan_next;
      clear_reply <= clear_reply_next;
      in_range    <= in_range_next;
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (response.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_byte <= held_byte_next;
    if (finish) begin
      rsp_cursor <= atcw_pkg::POS_W'(cursor_next);
      rsp_view   <= atcw_pkg::POS_W'(view_next);
      if (state == S_READ && in_range) begin
        rsp_char <= rd_q[CW-1:0];
        rsp_attr <= rd_q[atcw_pkg::CELL_W-1:CW];
      end else begin
        rsp_char <= '0;
        rsp_attr <= '0;
      end
    end
  end

endmodule
